// ===== sv/cqs_pkg.sv =====
package cqs_pkg;

    typedef enum logic [2:0] {
        CMD_SET_ACTIVE  = 3'd0,
        CMD_QUALITY     = 3'd1,
        CMD_BLACKLIST   = 3'd2,
        CMD_WHITELIST   = 3'd3,
        CMD_UNBLACKLIST = 3'd4,
        CMD_UNWHITELIST = 3'd5,
        CMD_QUERY       = 3'd6,
        CMD_SCAN        = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_UNKNOWN = 3'd0,
        ST_GOOD    = 3'd1,
        ST_IN_USE  = 3'd2,
        ST_BAD     = 3'd3,
        ST_BUSY    = 3'd4,
        ST_BLACK   = 3'd5,
        ST_WHITE   = 3'd6
    } chan_st_t;

    typedef enum logic [1:0] {
        CODE_OK        = 2'd0,
        CODE_BAD_CHAN  = 2'd1,
        CODE_BLACKED   = 2'd2,
        CODE_BAD_STATE = 2'd3
    } code_t;

    typedef enum logic [1:0] {
        OUT_PACKET   = 2'd0,
        OUT_NO_PKT   = 2'd1,
        OUT_BUSY     = 2'd2,
        OUT_PHY_ERR  = 2'd3
    } outcome_t;

    localparam logic [1:0] CFG_RSSI_THR = 2'd0;
    localparam logic [1:0] CFG_FER_THR  = 2'd1;
    localparam logic [1:0] CFG_RESEL_EN = 2'd2;
    localparam logic [1:0] CFG_PORTABLE = 2'd3;

    localparam logic signed [7:0] RSSI_THR_RESET = -8'sd90;
    localparam logic [6:0]        FER_THR_RESET  = 7'd20;
    localparam logic signed [7:0] RSSI_FLOOR     = -8'sd128;
    localparam logic signed [7:0] RSSI_INIT      = -8'sd127;
    localparam logic [6:0]        FER_INIT       = 7'd100;
    localparam logic [6:0]        FER_CRC_FAIL   = 7'd50;
    localparam logic [6:0]        FER_CRC_PASS   = 7'd0;

    typedef struct packed {
        logic [7:0] rssi_thr;
        logic [6:0] fer_thr;
        logic       resel_en;
        logic       portable;
    } cfg_t;

    // Write requests into the channel table. Later fields win on the same entry:
    // in-use over good over the addressed-channel status write.
    typedef struct packed {
        logic       st_we;
        chan_st_t   st;
        logic       q_we;
        logic [7:0] rssi;
        logic [6:0] fer;
        logic [4:0] ch_idx;
        logic       good_we;
        logic [4:0] good_idx;
        logic       inuse_we;
        logic [4:0] inuse_idx;
    } tbl_wr_t;

endpackage

// ===== sv/channel_quality_selector.sv =====
// A command taken at a clock edge lands in the command register; the table update
// and result are computed in a single pass from there into the result register,
// whose output is marked by done. One command per cycle, unless busy holds a
// command off while a configuration beat lands.
// Reset: rst_n returns the channel table, masks, tracking and configuration to their reset values.
module channel_quality_selector
    import cqs_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        command,
    input  logic [7:0]        channel,
    input  logic signed [7:0] rssi,
    input  logic [6:0]        fer,
    input  logic [1:0]        scan_outcome,
    input  logic              crc_ok,
    input  logic              scan_first,
    input  logic              scan_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              done,
    output logic [1:0]        status_code,
    output logic [4:0]        active_now,
    output logic              channel_changed,
    output logic              reselect_request,
    output logic [2:0]        chan_status,
    output logic signed [7:0] chan_rssi,
    output logic [6:0]        chan_fer
);

    localparam int CW = $clog2(CHANNELS);

    cfg_t          cfg;
    logic          in_flight;
    logic [CW-1:0] tbl_idx;
    chan_st_t      tbl_st;
    logic [7:0]    tbl_rssi;
    logic [6:0]    tbl_fer;
    tbl_wr_t       tbl_wr;

    // A configuration beat is held off while a command is in the pass, and a
    // command is held off in the cycle a configuration beat lands.
    assign cfg_ready = ~in_flight;
    assign busy      = cfg_valid & cfg_ready;

    cqs_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cqs_chan_table #(.CHANNELS(CHANNELS)) u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (tbl_idx),
        .rd_st   (tbl_st),
        .rd_rssi (tbl_rssi),
        .rd_fer  (tbl_fer),
        .wr      (tbl_wr)
    );

    cqs_core #(.CHANNELS(CHANNELS)) u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (start & ~busy),
        .command          (command),
        .channel          (channel),
        .rssi             (rssi),
        .fer              (fer),
        .scan_outcome     (scan_outcome),
        .crc_ok           (crc_ok),
        .scan_first       (scan_first),
        .scan_last        (scan_last),
        .cfg              (cfg),
        .in_flight        (in_flight),
        .tbl_idx          (tbl_idx),
        .tbl_st           (tbl_st),
        .tbl_rssi         (tbl_rssi),
        .tbl_fer          (tbl_fer),
        .tbl_wr           (tbl_wr),
        .done             (done),
        .status_code      (status_code),
        .active_now       (active_now),
        .channel_changed  (channel_changed),
        .reselect_request (reselect_request),
        .chan_status      (chan_status),
        .chan_rssi        (chan_rssi),
        .chan_fer         (chan_fer)
    );

endmodule

// ===== sv/cqs_cfg_regs.sv =====
module cqs_cfg_regs
    import cqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [7:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rssi_thr <= RSSI_THR_RESET;
            cfg_reg.fer_thr  <= FER_THR_RESET;
            cfg_reg.resel_en <= 1'b1;
            cfg_reg.portable <= 1'b1;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_RSSI_THR: cfg_reg.rssi_thr <= wr_data;
                CFG_FER_THR:  cfg_reg.fer_thr  <= wr_data[6:0];
                CFG_RESEL_EN: cfg_reg.resel_en <= wr_data[0];
                CFG_PORTABLE: cfg_reg.portable <= wr_data[0];
                default:      cfg_reg.portable <= cfg_reg.portable;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/cqs_chan_table.sv =====
module cqs_chan_table
    import cqs_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(CHANNELS)-1:0]  rd_idx,
    output chan_st_t                     rd_st,
    output logic [7:0]                   rd_rssi,
    output logic [6:0]                   rd_fer,
    input  tbl_wr_t                      wr
);

    localparam int CW = $clog2(CHANNELS);

    chan_st_t   st_reg   [CHANNELS];
    logic [7:0] rssi_reg [CHANNELS];
    logic [6:0] fer_reg  [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                st_reg[i]   <= (i == 0) ? ST_IN_USE : ST_UNKNOWN;
                rssi_reg[i] <= RSSI_INIT;
                fer_reg[i]  <= FER_INIT;
            end
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (wr.inuse_we && wr.inuse_idx[CW-1:0] == CW'(i))
                    st_reg[i] <= ST_IN_USE;
                else if (wr.good_we && wr.good_idx[CW-1:0] == CW'(i))
                    st_reg[i] <= ST_GOOD;
                else if (wr.st_we && wr.ch_idx[CW-1:0] == CW'(i))
                    st_reg[i] <= wr.st;
                if (wr.q_we && wr.ch_idx[CW-1:0] == CW'(i))
                begin
                    rssi_reg[i] <= wr.rssi;
                    fer_reg[i]  <= wr.fer;
                end
            end
        end
    end

    assign rd_st   = st_reg[rd_idx];
    assign rd_rssi = rssi_reg[rd_idx];
    assign rd_fer  = fer_reg[rd_idx];

endmodule

// ===== sv/cqs_core.sv =====
module cqs_core
    import cqs_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [2:0]                   command,
    input  logic [7:0]                   channel,
    input  logic signed [7:0]            rssi,
    input  logic [6:0]                   fer,
    input  logic [1:0]                   scan_outcome,
    input  logic                         crc_ok,
    input  logic                         scan_first,
    input  logic                         scan_last,
    input  cfg_t                         cfg,
    output logic                         in_flight,
    output logic [$clog2(CHANNELS)-1:0]  tbl_idx,
    input  chan_st_t                     tbl_st,
    input  logic [7:0]                   tbl_rssi,
    input  logic [6:0]                   tbl_fer,
    output tbl_wr_t                      tbl_wr,
    output logic                         done,
    output logic [1:0]                   status_code,
    output logic [4:0]                   active_now,
    output logic                         channel_changed,
    output logic                         reselect_request,
    output logic [2:0]                   chan_status,
    output logic signed [7:0]            chan_rssi,
    output logic [6:0]                   chan_fer
);

    localparam int CW = $clog2(CHANNELS);

    logic              v_reg;
    logic [2:0]        cmd_reg;
    logic [7:0]        ch_reg;
    logic signed [7:0] rssi_reg;
    logic [6:0]        fer_reg;
    logic [1:0]        outcome_reg;
    logic              crc_reg;
    logic              first_reg;
    logic              last_reg;

    logic [CW-1:0]       active_reg,    active_next;
    logic [CHANNELS-1:0] black_reg,     black_next;
    logic [CHANNELS-1:0] white_reg,     white_next;
    logic signed [7:0]   peak_rssi_reg, peak_rssi_next;
    logic [CW-1:0]       best_ch_reg,   best_ch_next;
    logic                found_reg,     found_next;

    logic              done_reg;
    code_t             code_reg,    code_next;
    logic [4:0]        act_out_reg;
    logic              changed_reg, changed_next;
    logic              resel_reg,   resel_next;
    chan_st_t          st_out_reg,  st_out_next;
    logic signed [7:0] r_out_reg,   r_out_next;
    logic [6:0]        f_out_reg,   f_out_next;

    logic              valid;
    logic [CW-1:0]     chi;
    logic              may;
    logic              cur_black;
    logic              cur_white;
    logic [6:0]        q_fer;
    logic              q_bad;
    chan_st_t          q_st;
    logic              q_resel;
    logic signed [7:0] base_r;
    logic [CW-1:0]     base_c;
    logic              base_f;
    chan_st_t          s_st;
    logic signed [7:0] s_rssi;
    logic [6:0]        s_fer;
    logic              best_white;
    logic              take;
    logic signed [7:0] t_r;
    logic [CW-1:0]     t_c;
    logic              t_f;
    logic              sw_go;
    logic [CW-1:0]     sw_tgt;
    tbl_wr_t           tw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= command;
            ch_reg      <= channel;
            rssi_reg    <= rssi;
            fer_reg     <= fer;
            outcome_reg <= scan_outcome;
            crc_reg     <= crc_ok;
            first_reg   <= scan_first;
            last_reg    <= scan_last;
        end
    end

    assign valid     = ch_reg < 8'(CHANNELS);
    assign chi       = ch_reg[CW-1:0];
    assign tbl_idx   = chi;
    assign may       = cfg.portable & cfg.resel_en;
    assign cur_black = black_reg[chi];
    assign cur_white = white_reg[chi];

    assign q_fer   = (cmd_t'(cmd_reg) == CMD_SCAN) ? (crc_reg ? FER_CRC_PASS : FER_CRC_FAIL)
                                                   : fer_reg;
    assign q_bad   = (rssi_reg < $signed(cfg.rssi_thr)) || (q_fer > cfg.fer_thr);
    assign q_st    = q_bad ? ST_BAD : ((!cur_black && !cur_white) ? ST_GOOD : tbl_st);
    assign q_resel = q_bad && (tbl_st == ST_IN_USE) && may;

    assign base_r = first_reg ? RSSI_FLOOR : peak_rssi_reg;
    assign base_c = first_reg ? active_reg : best_ch_reg;
    assign base_f = first_reg ? 1'b0 : found_reg;

    always_comb
    begin
        s_st   = tbl_st;
        s_rssi = $signed(tbl_rssi);
        s_fer  = tbl_fer;
        case (outcome_t'(outcome_reg))
            OUT_PACKET:
            begin
                s_st   = q_st;
                s_rssi = rssi_reg;
                s_fer  = q_fer;
            end
            OUT_NO_PKT:  s_st = (tbl_st == ST_UNKNOWN) ? ST_GOOD : tbl_st;
            OUT_BUSY:    s_st = ST_BUSY;
            default:     s_st = tbl_st;
        endcase
    end

    assign best_white = white_reg[base_c];

    always_comb
    begin
        if (s_st != ST_GOOD && s_st != ST_WHITE && s_st != ST_IN_USE)
            take = 1'b0;
        else if (cur_white)
            take = !best_white || (s_rssi > base_r);
        else
            take = !best_white && (s_rssi > base_r) &&
                   (s_rssi >= $signed(cfg.rssi_thr)) && (s_fer <= cfg.fer_thr);
    end

    assign t_r = (take && !cur_black) ? s_rssi : base_r;
    assign t_c = (take && !cur_black) ? chi    : base_c;
    assign t_f = (take && !cur_black) ? 1'b1   : base_f;

    always_comb
    begin
        active_next    = active_reg;
        black_next     = black_reg;
        white_next     = white_reg;
        peak_rssi_next = peak_rssi_reg;
        best_ch_next   = best_ch_reg;
        found_next     = found_reg;
        code_next      = CODE_OK;
        changed_next   = 1'b0;
        resel_next     = 1'b0;
        sw_go          = 1'b0;
        sw_tgt         = chi;
        tw             = '0;
        tw.ch_idx      = 5'(chi);
        tw.rssi        = rssi_reg;
        tw.fer         = q_fer;

        if (v_reg)
        begin
            if (!valid)
                code_next = CODE_BAD_CHAN;
            else
            begin
                case (cmd_t'(cmd_reg))
                    CMD_SET_ACTIVE:
                    begin
                        if (chi != active_reg)
                        begin
                            if (cur_black)
                                code_next = CODE_BLACKED;
                            else
                                sw_go = 1'b1;
                        end
                    end
                    CMD_QUALITY:
                    begin
                        tw.q_we    = 1'b1;
                        tw.st_we   = 1'b1;
                        tw.st      = q_st;
                        resel_next = q_resel;
                    end
                    CMD_BLACKLIST:
                    begin
                        black_next[chi] = 1'b1;
                        tw.st_we        = 1'b1;
                        tw.st           = ST_BLACK;
                        resel_next      = (chi == active_reg) && may;
                    end
                    CMD_WHITELIST:
                    begin
                        white_next[chi] = 1'b1;
                        tw.st_we        = 1'b1;
                        tw.st           = ST_WHITE;
                    end
                    CMD_UNBLACKLIST:
                    begin
                        black_next[chi] = 1'b0;
                        tw.st_we        = 1'b1;
                        tw.st           = ST_UNKNOWN;
                    end
                    CMD_UNWHITELIST:
                    begin
                        white_next[chi] = 1'b0;
                        tw.st_we        = 1'b1;
                        tw.st           = ST_UNKNOWN;
                    end
                    CMD_SCAN:
                    begin
                        if (!may)
                            code_next = CODE_BAD_STATE;
                        else
                        begin
                            tw.st_we = 1'b1;
                            if (cur_black)
                                tw.st = ST_BLACK;
                            else
                            begin
                                tw.st = s_st;
                                if (outcome_t'(outcome_reg) == OUT_PACKET)
                                begin
                                    tw.q_we    = 1'b1;
                                    resel_next = q_resel;
                                end
                            end
                            peak_rssi_next = t_r;
                            best_ch_next   = t_c;
                            found_next     = t_f;
                            if (last_reg)
                            begin
                                found_next = 1'b0;
                                sw_tgt     = t_c;
                                if (t_f && t_c != active_reg)
                                begin
                                    if (black_reg[t_c])
                                        code_next = CODE_BLACKED;
                                    else
                                        sw_go = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        code_next = CODE_OK;
                    end
                endcase
            end

            if (sw_go)
            begin
                tw.good_we    = 1'b1;
                tw.good_idx   = 5'(active_reg);
                tw.inuse_we   = 1'b1;
                tw.inuse_idx  = 5'(sw_tgt);
                active_next   = sw_tgt;
                changed_next  = 1'b1;
            end
        end
    end

    assign tbl_wr = tw;

    always_comb
    begin
        if (!valid)
        begin
            st_out_next = ST_UNKNOWN;
            r_out_next  = '0;
            f_out_next  = '0;
        end
        else
        begin
            if (tw.inuse_we && tw.inuse_idx == 5'(chi))
                st_out_next = ST_IN_USE;
            else if (tw.good_we && tw.good_idx == 5'(chi))
                st_out_next = ST_GOOD;
            else if (tw.st_we)
                st_out_next = tw.st;
            else
                st_out_next = tbl_st;
            r_out_next = tw.q_we ? tw.rssi : $signed(tbl_rssi);
            f_out_next = tw.q_we ? tw.fer  : tbl_fer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            black_reg     <= '0;
            white_reg     <= '0;
            peak_rssi_reg <= RSSI_FLOOR;
            best_ch_reg   <= '0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            black_reg     <= black_next;
            white_reg     <= white_next;
            peak_rssi_reg <= peak_rssi_next;
            best_ch_reg   <= best_ch_next;
            found_reg     <= found_next;
            done_reg      <= v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_reg)
        begin
            code_reg    <= code_next;
            act_out_reg <= 5'(active_next);
            changed_reg <= changed_next;
            resel_reg   <= resel_next;
            st_out_reg  <= st_out_next;
            r_out_reg   <= r_out_next;
            f_out_reg   <= f_out_next;
        end
    end

    assign in_flight        = v_reg;
    assign done             = done_reg;
    assign status_code      = code_reg;
    assign active_now       = act_out_reg;
    assign channel_changed  = changed_reg;
    assign reselect_request = resel_reg;
    assign chan_status      = st_out_reg;
    assign chan_rssi        = r_out_reg;
    assign chan_fer         = f_out_reg;

endmodule

// ===== sv/cqs_checker.sv =====
module cqs_checker
    import cqs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status_code,
    input logic [4:0] active_now,
    input logic       channel_changed,
    input logic [2:0] chan_status,
    input logic [7:0] chan_rssi,
    input logic [6:0] chan_fer
);

    // Every accepted command gives exactly one result beat on done.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted command produced no result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result beat without an accepted command");

    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && channel_changed) |-> (status_code == CODE_OK))
        else $error("channel switch reported with a failing status code");

    a_bad_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_code == CODE_BAD_CHAN) |->
            (chan_status == ST_UNKNOWN && chan_rssi == 8'd0 && chan_fer == 7'd0))
        else $error("invalid channel reported nonzero channel data");

    a_active_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done) && !channel_changed) |-> (active_now == $past(active_now)))
        else $error("active channel moved without a switch");

endmodule

bind channel_quality_selector cqs_checker u_cqs_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .status_code     (status_code),
    .active_now      (active_now),
    .channel_changed (channel_changed),
    .chan_status     (chan_status),
    .chan_rssi       (chan_rssi),
    .chan_fer        (chan_fer)
);
